>>> hdl/mexp_pkg.sv
// Shared types and constants for the modular exponentiation block.
`default_nettype none

package mexp_pkg;

   // Width of base, exponent, modulus and result.
   localparam int OPERAND_WIDTH = 62;
   // Width of the bit counter used while reducing the base.
   localparam int CNT_WIDTH = $clog2(OPERAND_WIDTH);

   typedef logic [OPERAND_WIDTH-1:0] operand_type;
   typedef logic [CNT_WIDTH-1:0] count_type;

   // Operands for one pass through the shared add-and-reduce unit.
   typedef struct packed {
      operand_type a;
      operand_type b;
      operand_type m;
      logic        cin;
   } addred_req_type;

endpackage

`default_nettype wire

>>> hdl/modular_exponentiation.sv
// Top level: sequencer for right-to-left square-and-multiply modular exponentiation.
// Sequence: the base is first reduced modulo the modulus one bit at a time (ST_REDUCE).
// Then for each exponent bit a decision state (ST_LOOP) starts a multiply when the bit is set,
// and a square; each is done as shift-and-add passes through the shared unit over the bits of
// the multiplier (ST_MUL_A, with ST_MUL_B for set multiplier bits), then a finish step.
// Throughput: one beat at a time; busy stays high until the result strobe, and a new beat
// may start in the strobe cycle. The receiver cannot stall the result.
// Reset: synchronous, active high; clears the sequencer and the result strobe.
`default_nettype none

module modular_exponentiation (
   input  wire                        clock,
   input  wire                        reset,
   input  wire                        start,
   output logic                       busy,
   input  wire mexp_pkg::operand_type req_base_value,
   input  wire mexp_pkg::operand_type req_exponent_value,
   input  wire mexp_pkg::operand_type req_modulus_value,
   output logic                       rsp_valid,
   output mexp_pkg::operand_type      rsp_power_result
);
   import mexp_pkg::*;

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_REDUCE = 3'd1;
   localparam logic [2:0] ST_LOOP   = 3'd2;
   localparam logic [2:0] ST_MUL_A  = 3'd3;
   localparam logic [2:0] ST_MUL_B  = 3'd4;

   logic [2:0]  state_ff, state_in;
   logic        rsp_valid_ff, rsp_valid_in;
   operand_type rsp_result_ff, rsp_result_in;
   operand_type base_ff, base_in;
   operand_type exp_ff, exp_in;
   operand_type mod_ff, mod_in;
   operand_type sq_ff, sq_in;
   operand_type res_ff, res_in;
   operand_type acc_ff, acc_in;
   operand_type addend_ff, addend_in;
   operand_type mb_ff, mb_in;
   logic        mul_sq_ff, mul_sq_in;
   count_type   cnt_ff, cnt_in;

   addred_req_type unit_req;
   operand_type    unit_sum;

   mexp_addred u_addred (
      .req (unit_req),
      .sum (unit_sum)
   );

   assign busy             = (state_ff != ST_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_power_result = rsp_result_ff;

   // Operand select for the shared unit.
   always_comb begin
      unit_req.m = mod_ff;
      case (state_ff)
         ST_REDUCE: begin
            unit_req.a   = sq_ff;
            unit_req.b   = sq_ff;
            unit_req.cin = base_ff[OPERAND_WIDTH-1];
         end
         ST_MUL_A: begin
            if (mb_ff[0]) begin
               unit_req.a = acc_ff;
               unit_req.b = addend_ff;
            end else begin
               unit_req.a = addend_ff;
               unit_req.b = addend_ff;
            end
            unit_req.cin = 1'b0;
         end
         default: begin
            unit_req.a   = addend_ff;
            unit_req.b   = addend_ff;
            unit_req.cin = 1'b0;
         end
      endcase
   end

   // Sequencer next-state logic.
   always_comb begin
      state_in      = state_ff;
      rsp_valid_in  = 1'b0;
      rsp_result_in = rsp_result_ff;
      base_in       = base_ff;
      exp_in        = exp_ff;
      mod_in        = mod_ff;
      sq_in         = sq_ff;
      res_in        = res_ff;
      acc_in        = acc_ff;
      addend_in     = addend_ff;
      mb_in         = mb_ff;
      mul_sq_in     = mul_sq_ff;
      cnt_in        = cnt_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               base_in = req_base_value;
               exp_in  = req_exponent_value;
               mod_in  = req_modulus_value;
               sq_in   = '0;
               cnt_in  = '0;
               res_in  = (req_modulus_value == operand_type'(1)) ? '0 : operand_type'(1);
               if (req_modulus_value == '0) begin
                  // Zero modulus answers zero without any arithmetic.
                  exp_in   = '0;
                  res_in   = '0;
                  state_in = ST_LOOP;
               end else begin
                  state_in = ST_REDUCE;
               end
            end
         end
         ST_REDUCE: begin
            // Restoring remainder: shift in one base bit per cycle, MSB first.
            sq_in   = unit_sum;
            base_in = {base_ff[OPERAND_WIDTH-2:0], 1'b0};
            cnt_in  = cnt_ff + count_type'(1);
            if (cnt_ff == count_type'(OPERAND_WIDTH - 1)) begin
               state_in = ST_LOOP;
            end
         end
         ST_LOOP: begin
            acc_in = '0;
            mb_in  = sq_ff;
            if (exp_ff == '0) begin
               rsp_valid_in  = 1'b1;
               rsp_result_in = res_ff;
               state_in      = ST_IDLE;
            end else if (exp_ff[0]) begin
               addend_in = res_ff;
               mul_sq_in = 1'b0;
               state_in  = ST_MUL_A;
            end else begin
               addend_in = sq_ff;
               mul_sq_in = 1'b1;
               state_in  = ST_MUL_A;
            end
         end
         ST_MUL_A: begin
            if (mb_ff == '0) begin
               // Multiply finished: the product sits in the accumulator.
               if (!mul_sq_ff) begin
                  res_in = acc_ff;
                  if (exp_ff[OPERAND_WIDTH-1:1] == '0) begin
                     // Last set bit: the final square is never used.
                     exp_in   = '0;
                     state_in = ST_LOOP;
                  end else begin
                     acc_in    = '0;
                     addend_in = sq_ff;
                     mb_in     = sq_ff;
                     mul_sq_in = 1'b1;
                  end
               end else begin
                  sq_in    = acc_ff;
                  exp_in   = exp_ff >> 1;
                  state_in = ST_LOOP;
               end
            end else if (mb_ff[0]) begin
               acc_in   = unit_sum;
               state_in = ST_MUL_B;
            end else begin
               addend_in = unit_sum;
               mb_in     = mb_ff >> 1;
            end
         end
         ST_MUL_B: begin
            addend_in = unit_sum;
            mb_in     = mb_ff >> 1;
            state_in  = ST_MUL_A;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      rsp_result_ff <= rsp_result_in;
      base_ff       <= base_in;
      exp_ff        <= exp_in;
      mod_ff        <= mod_in;
      sq_ff         <= sq_in;
      res_ff        <= res_in;
      acc_ff        <= acc_in;
      addend_ff     <= addend_in;
      mb_ff         <= mb_in;
      mul_sq_ff     <= mul_sq_in;
      cnt_ff        <= cnt_in;
   end

   // A finished job always leaves with a result strobe.
   a_done_strobe: assert property (@(posedge clock) disable iff (reset)
      $fell(busy) |-> rsp_valid)
      else $error("busy fell without a result strobe");

   // An accepted beat always makes the block busy.
   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted beat did not start the sequencer");

   // The result is always reduced below the modulus, or zero for a zero modulus.
   a_result_reduced: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_power_result < mod_ff) || (mod_ff == '0)))
      else $error("result not reduced by the modulus");

   // The partial remainder stays below the modulus during base reduction.
   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_REDUCE) |-> (sq_ff < mod_ff))
      else $error("partial remainder out of range");

endmodule

`default_nettype wire

>>> hdl/mexp_addred.sv
// Shared add-and-reduce unit: (a + b + cin) mod m for a, b below m.
`default_nettype none

module mexp_addred (
   input  wire mexp_pkg::addred_req_type req,
   output mexp_pkg::operand_type         sum
);
   import mexp_pkg::*;

   logic [OPERAND_WIDTH:0] raw_sum;
   logic [OPERAND_WIDTH:0] wide_mod;
   logic [OPERAND_WIDTH:0] reduced;

   // One wide add, then a single conditional subtract since the sum stays below 2m.
   assign raw_sum  = {1'b0, req.a} + {1'b0, req.b} + {{OPERAND_WIDTH{1'b0}}, req.cin};
   assign wide_mod = {1'b0, req.m};
   assign reduced  = (raw_sum >= wide_mod) ? (raw_sum - wide_mod) : raw_sum;
   assign sum      = reduced[OPERAND_WIDTH-1:0];

endmodule

`default_nettype wire

>>> dv/modular_exponentiation_tb.sv
// Self-checking testbench for the modular exponentiation block.
`default_nettype none

module modular_exponentiation_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import mexp_pkg::*;

   localparam int DIRECTED_BEATS = 17;
   localparam int RANDOM_BEATS = 100;
   // No beat or result for this many cycles means the block is hung.
   localparam int HANG_LIMIT = 100000;
   // Quiet time after the last result, about one worst-case exponentiation.
   localparam int SETTLE_CYCLES = 16000;
   localparam int REPORT_LIMIT = 10;

   // Predicts each power and checks results in order.
   class power_scoreboard;
      operand_type expected_q[$];
      int unsigned checked;
      int unsigned failures;

      // Full-width product reduced by the modulus.
      function operand_type mul_mod(operand_type a, operand_type b, operand_type m);
         logic [2*OPERAND_WIDTH-1:0] wide;
         wide = {{OPERAND_WIDTH{1'b0}}, a} * {{OPERAND_WIDTH{1'b0}}, b};
         wide = wide % {{OPERAND_WIDTH{1'b0}}, m};
         return wide[OPERAND_WIDTH-1:0];
      endfunction

      // Right-to-left square-and-multiply; a zero modulus answers zero.
      function operand_type predict_power(operand_type b, operand_type e, operand_type m);
         operand_type acc;
         operand_type sq;
         if (m == '0) begin
            return '0;
         end
         acc = (m == operand_type'(1)) ? '0 : operand_type'(1);
         sq = b % m;
         for (int i = 0; i < OPERAND_WIDTH; i++) begin
            if (e[i]) begin
               acc = mul_mod(acc, sq, m);
            end
            sq = mul_mod(sq, sq, m);
         end
         return acc;
      endfunction

      function void note_request(operand_type b, operand_type e, operand_type m);
         expected_q.insert(expected_q.size(), predict_power(b, e, m));
      endfunction

      function void check_result(operand_type got);
         operand_type want;
         if (expected_q.size() == 0) begin
            failures++;
            if (failures <= REPORT_LIMIT) begin
               $display("ERROR: result %h with no beat outstanding", got);
            end
            return;
         end
         want = expected_q.pop_front();
         checked++;
         if (got !== want) begin
            failures++;
            if (failures <= REPORT_LIMIT) begin
               $display("ERROR: power_result expected %h, got %h", want, got);
            end
         end
      endfunction

      function int pending();
         return expected_q.size();
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   operand_type req_base_value = '0;
   operand_type req_exponent_value = '0;
   operand_type req_modulus_value = '0;
   logic        rsp_valid;
   operand_type rsp_power_result;

   power_scoreboard sb = new();
   int unsigned beats_sent = 0;
   int unsigned drain_pauses = 0;
   int unsigned quiet_cycles = 0;

   modular_exponentiation i_dut (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_base_value     (req_base_value),
      .req_exponent_value (req_exponent_value),
      .req_modulus_value  (req_modulus_value),
      .rsp_valid          (rsp_valid),
      .rsp_power_result   (rsp_power_result)
   );

   // 10 ns clock.
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Results cannot be held off, so every strobe is checked at once.
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         sb.check_result(rsp_power_result);
      end
   end

   // Hang detection: count cycles in which neither a beat nor a result moves.
   always @(posedge clock) begin
      if ((start && !busy && !reset) || rsp_valid) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= HANG_LIMIT) begin
         $display("ERROR: no activity for %0d cycles, %0d results outstanding",
                  HANG_LIMIT, sb.pending());
         $display("FAIL");
         $finish;
      end
   end

   // Presents one beat and returns at the edge that accepts it; start stays high.
   task automatic send_beat(input operand_type b, input operand_type e, input operand_type m);
      start <= 1'b1;
      req_base_value <= b;
      req_exponent_value <= e;
      req_modulus_value <= m;
      do @(posedge clock); while (busy);
      sb.note_request(b, e, m);
      beats_sent++;
   endtask

   // Idles the request side for a number of cycles.
   task automatic idle_gap(input int unsigned cycles);
      if (cycles > 0) begin
         start <= 1'b0;
         repeat (cycles) @(posedge clock);
      end
   endtask

   // Holds off new beats until every outstanding result has come back.
   task automatic drain_results();
      start <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
      drain_pauses++;
   endtask

   // Random value with a random number of significant bits.
   function automatic operand_type random_operand(int unsigned nbits);
      operand_type v;
      v = operand_type'({$urandom, $urandom});
      if (nbits < OPERAND_WIDTH) begin
         v &= (operand_type'(1) << nbits) - operand_type'(1);
      end
      return v;
   endfunction

   // One random beat, shaped by a randomly chosen flavor.
   task automatic send_random_beat();
      operand_type b;
      operand_type e;
      operand_type m;
      int unsigned flavor;
      flavor = $urandom_range(0, 7);
      b = random_operand(OPERAND_WIDTH);
      e = random_operand(OPERAND_WIDTH);
      m = random_operand(OPERAND_WIDTH);
      case (flavor)
         4: begin
            // Tiny modulus, so most base values need reducing.
            m = operand_type'($urandom_range(1, 255));
         end
         5: begin
            b = random_operand($urandom_range(1, OPERAND_WIDTH));
            e = random_operand($urandom_range(1, OPERAND_WIDTH));
            m = random_operand($urandom_range(1, OPERAND_WIDTH));
         end
         6: begin
            // Base at or above the modulus.
            m = random_operand($urandom_range(1, OPERAND_WIDTH - 1));
            b = b | (operand_type'(1) << (OPERAND_WIDTH - 1));
         end
         7: begin
            e = ($urandom_range(0, 1) == 0) ? operand_type'($urandom_range(0, 15)) : '1;
         end
         default: begin
         end
      endcase
      if (m == '0) begin
         m = operand_type'(1);
      end
      send_beat(b, e, m);
   endtask

   initial begin
      operand_type all_ones;
      operand_type alt_a;
      operand_type alt_b;
      int unsigned burst;
      int unsigned pick;

      all_ones = '1;
      alt_a = {(OPERAND_WIDTH / 2){2'b10}};
      alt_b = {(OPERAND_WIDTH / 2){2'b01}};

      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed beats: field extremes, zero exponent, modulus one, unreduced base.
      send_beat('0, '0, operand_type'(1));
      send_beat(operand_type'(5), '0, operand_type'(7));
      send_beat('0, '0, all_ones);
      send_beat(all_ones, '0, operand_type'(1));
      send_beat('0, all_ones, all_ones);
      idle_gap(3);
      send_beat(all_ones, all_ones, all_ones);
      send_beat(all_ones, all_ones, all_ones - operand_type'(1));
      send_beat(all_ones, operand_type'(1), operand_type'(1000003));
      send_beat(operand_type'(1), all_ones, all_ones);
      drain_results();
      send_beat(operand_type'(2), operand_type'(61), all_ones);
      send_beat(operand_type'(2), operand_type'(62), all_ones);
      send_beat(all_ones - operand_type'(1), operand_type'(2), all_ones);
      send_beat(operand_type'(3), operand_type'(1000), operand_type'(2));
      idle_gap(7);
      send_beat(operand_type'(12345), operand_type'(1), operand_type'(100));
      send_beat(alt_a, alt_b, alt_a | operand_type'(1));
      send_beat(operand_type'(3), all_ones, operand_type'(1) << (OPERAND_WIDTH - 1));
      send_beat(operand_type'(1000), operand_type'(5), operand_type'(1));

      // Let everything in flight finish before the random traffic starts.
      drain_results();

      // Random traffic in bursts; gaps land at random points in the computation.
      while (beats_sent < DIRECTED_BEATS + RANDOM_BEATS) begin
         burst = $urandom_range(1, 4);
         repeat (burst) send_random_beat();
         pick = $urandom_range(0, 9);
         if (pick == 0) begin
            drain_results();
            idle_gap($urandom_range(0, 3));
         end else if (pick >= 4) begin
            idle_gap($urandom_range(1, 40));
         end
      end

      // Wait for the last results, then watch for any stray strobe.
      start <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("Run covered %0d beats (%0d directed) and %0d checked results,",
               beats_sent, DIRECTED_BEATS, sb.checked);
      $display("with %0d pauses that waited for the block to empty.", drain_pauses);
      if (sb.pending() != 0) begin
         $display("ERROR: %0d results never arrived", sb.pending());
      end
      if (sb.failures > REPORT_LIMIT) begin
         $display("%0d further mismatches not shown", sb.failures - REPORT_LIMIT);
      end
      if (sb.failures == 0 && sb.pending() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

`default_nettype wire
